// ===== hw/rtl/b64sd_pkg.sv =====
// Shared types, constants and character decode helpers for the base64 stream decoder.
`default_nettype none

package b64sd_pkg;

    localparam int unsigned LEN_W           = 24;  // capacity and status count width
    localparam int unsigned COUNT_BITS_DEF  = 24;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned APB_ADDR_W      = 3;
    localparam int unsigned APB_DATA_W      = 32;

    localparam logic             REG_MAX_LEN   = 1'b0;  // register index 0
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = '1;

    localparam int unsigned SYM_LOWER_BASE = 26;
    localparam int unsigned SYM_DIGIT_BASE = 52;
    localparam logic [5:0]  SYM_PLUS       = 6'd62;
    localparam logic [5:0]  SYM_SLASH      = 6'd63;
    localparam logic [7:0]  CH_PAD         = 8'h3D;  // '='

    typedef enum logic [2:0] {
        RSN_NONE      = 3'd0,
        RSN_BAD_CHAR  = 3'd1,
        RSN_PADS      = 3'd2,
        RSN_AFTER_PAD = 3'd3,
        RSN_LENGTH    = 3'd4,
        RSN_CAPACITY  = 3'd5
    } t_reason;

    // One queue entry: up to three data beats, then an optional status beat.
    typedef struct packed {
        logic [1:0]       nbytes;
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [7:0]       b2;
        logic             stat;
        logic             ok;
        t_reason          reason;
        logic [LEN_W-1:0] count;
    } t_entry;

    // {valid, 6-bit symbol value}
    function automatic logic [6:0] sym_lookup(input logic [7:0] c);
        logic [6:0] r;
        r = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'(SYM_LOWER_BASE))};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'(SYM_DIGIT_BASE))};
        end else if (c == 8'h2B) begin
            r = {1'b1, SYM_PLUS};
        end else if (c == 8'h2F) begin
            r = {1'b1, SYM_SLASH};
        end
        return r;
    endfunction

    // space, tab, CR, LF
    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/base64_stream_decoder_unit.sv =====
// Top level of the streaming base64 decoder: config register, front, queue, back.
`default_nettype none

// Channel  | Direction | Handshake          | Beat payload
// ---------+-----------+--------------------+---------------------------------------------
// input    | in        | i_valid / o_stall  | i_has_byte, i_char_in, i_is_last
// output   | out       | o_valid / i_stall  | o_kind, o_byte_out, o_ok, o_reason,
//          |           |                    | o_byte_count, o_run_end
// config   | in/out    | APB (psel..pready) | max_output_len at byte address 0
//
// The front takes one input beat per cycle while the queue has room; a character
// is classified and the message state updated in that same cycle.
// The back register sends one result beat per cycle while i_stall is low; an item
// yields 0 to 4 result beats, and the queue absorbs bursts.
// o_stall is high only while the queue is full; the output register refills in
// the cycle it is taken, so i_stall only backs up the queue.
// Reset (synchronous, active low) clears message state, empties queue and output,
// and sets max_output_len to all ones.

module base64_stream_decoder_unit
    import b64sd_pkg::*;
#(
    parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // input characters
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_has_byte,
    input  wire logic [7:0]            i_char_in,
    input  wire logic                  i_is_last,

    // results
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_kind,
    output logic [7:0]                 o_byte_out,
    output logic                       o_ok,
    output logic [2:0]                 o_reason,
    output logic [LEN_W-1:0]           o_byte_count,
    output logic                       o_run_end,

    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [LEN_W-1:0] r_max_len;
    logic             cfg_wr;
    logic             sel_max;

    logic             q_push, q_pop, q_empty, q_full;
    t_entry           q_in, q_head;

    // ---- configuration register ----
    // Register index is the word address bit; only index 0 exists.
    assign pready  = 1'b1;
    assign sel_max = (paddr[APB_ADDR_W-1] == REG_MAX_LEN);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = sel_max ? {{(APB_DATA_W - LEN_W){1'b0}}, r_max_len} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (cfg_wr && sel_max) begin
            r_max_len <= pwdata[LEN_W-1:0];
        end
    end

    // ---- front: decode and message bookkeeping ----
    assign o_stall = q_full;

    b64sd_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_full     (q_full),
        .i_has_byte (i_has_byte),
        .i_char_in  (i_char_in),
        .i_is_last  (i_is_last),
        .i_max_len  (r_max_len),
        .o_push     (q_push),
        .o_entry    (q_in)
    );

    // ---- queue: one entry per item that yields results ----
    b64sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // ---- back: one result beat per cycle while not stalled ----
    b64sd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_head       (q_head),
        .i_stall      (i_stall),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_byte_out   (o_byte_out),
        .o_ok         (o_ok),
        .o_reason     (o_reason),
        .o_byte_count (o_byte_count),
        .o_run_end    (o_run_end)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/b64sd_front.sv =====
// Front end: classifies characters, tracks message state, builds queue entries.
`default_nettype none

module b64sd_front
    import b64sd_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_full,
    input  wire logic             i_has_byte,
    input  wire logic [7:0]       i_char_in,
    input  wire logic             i_is_last,
    input  wire logic [LEN_W-1:0] i_max_len,
    output logic                  o_push,
    output t_entry                o_entry
);

    localparam int unsigned CNT_W = COUNT_BITS + 1;
    localparam int unsigned EXT_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 2;

    logic [17:0]      r_accum, n_accum;
    logic [1:0]       r_phase, n_phase;
    logic [1:0]       r_pad,   n_pad;
    t_reason          r_err,   n_err;
    logic [CNT_W-1:0] r_total, n_total;

    logic             accept;
    logic [6:0]       sym;
    logic             active;
    logic             grp;
    logic [23:0]      grp_word;
    logic [EXT_W-1:0] t_ext, lim_ext, max_ext, s1, s2, s3, fin;
    logic             e0, e1, e2;
    logic [1:0]       grp_n, tail;
    t_reason          rsn;
    t_entry           ent;

    // saturating add at the all-ones total limit
    function automatic logic [EXT_W-1:0] sat_add(input logic [EXT_W-1:0] a,
                                                 input logic [EXT_W-1:0] lim,
                                                 input logic [1:0]       k);
        logic [EXT_W-1:0] s;
        s = a + EXT_W'(k);
        return (s > lim) ? lim : s;
    endfunction

    assign accept   = i_valid & ~i_full;
    assign sym      = sym_lookup(i_char_in);
    assign active   = i_has_byte && (r_err == RSN_NONE) && !is_blank(i_char_in);
    assign grp_word = {r_accum, sym[5:0]};

    assign t_ext   = EXT_W'(r_total);
    assign lim_ext = EXT_W'({CNT_W{1'b1}});
    assign max_ext = EXT_W'(i_max_len);
    assign s1      = sat_add(t_ext, lim_ext, 2'd1);
    assign s2      = sat_add(t_ext, lim_ext, 2'd2);
    assign s3      = sat_add(t_ext, lim_ext, 2'd3);

    // a group is only taken with no error pending, so only capacity gates bytes
    assign e0    = t_ext < max_ext;
    assign e1    = s1 < max_ext;
    assign e2    = s2 < max_ext;
    assign grp_n = 2'(e0) + 2'(e1) + 2'(e2);

    always_comb begin
        n_accum = r_accum;
        n_phase = r_phase;
        n_pad   = r_pad;
        n_err   = r_err;
        grp     = 1'b0;
        if (active) begin
            if (i_char_in == CH_PAD) begin
                if (r_pad >= 2'd2) begin
                    n_err = RSN_PADS;
                end else begin
                    n_pad = r_pad + 2'd1;
                end
            end else if (!sym[6]) begin
                n_err = RSN_BAD_CHAR;
            end else if (r_pad != 2'd0) begin
                n_err = RSN_AFTER_PAD;
            end else if (r_phase == 2'd3) begin
                grp     = 1'b1;
                n_accum = '0;
                n_phase = 2'd0;
            end else begin
                n_accum = {r_accum[11:0], sym[5:0]};
                n_phase = r_phase + 2'd1;
            end
        end
        n_total = grp ? CNT_W'(s3) : r_total;
    end

    always_comb begin
        case (n_phase)
            2'd2:    tail = 2'd1;
            2'd3:    tail = 2'd2;
            default: tail = 2'd0;
        endcase
        fin = EXT_W'(n_total) + EXT_W'(tail);

        rsn = n_err;
        if (rsn == RSN_NONE && (n_phase + n_pad) != 2'd0) begin
            rsn = RSN_LENGTH;
        end
        if (rsn == RSN_NONE && fin > max_ext) begin
            rsn = RSN_CAPACITY;
        end

        ent        = '0;
        ent.reason = RSN_NONE;
        if (grp) begin
            ent.nbytes = grp_n;
            ent.b0     = grp_word[23:16];
            ent.b1     = grp_word[15:8];
            ent.b2     = grp_word[7:0];
        end
        if (i_is_last) begin
            ent.stat   = 1'b1;
            ent.reason = rsn;
            if (rsn == RSN_NONE) begin
                ent.ok    = 1'b1;
                ent.count = LEN_W'(fin);
                // tail bytes; never together with a completed group
                if (n_phase == 2'd2) begin
                    ent.nbytes = 2'd1;
                    ent.b0     = n_accum[11:4];
                end else if (n_phase == 2'd3) begin
                    ent.nbytes = 2'd2;
                    ent.b0     = n_accum[17:10];
                    ent.b1     = n_accum[9:2];
                end
            end
        end
    end

    assign o_entry = ent;
    assign o_push  = accept && (ent.stat || ent.nbytes != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_phase <= '0;
            r_pad   <= '0;
            r_err   <= RSN_NONE;
            r_total <= '0;
        end else if (accept) begin
            if (i_is_last) begin
                r_accum <= '0;
                r_phase <= '0;
                r_pad   <= '0;
                r_err   <= RSN_NONE;
                r_total <= '0;
            end else begin
                r_accum <= n_accum;
                r_phase <= n_phase;
                r_pad   <= n_pad;
                r_err   <= n_err;
                r_total <= n_total;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64sd_queue.sv =====
// Small entry queue between front and back ends.
`default_nettype none

module b64sd_queue
    import b64sd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_entry      i_entry,
    input  wire logic   i_pop,
    output t_entry      o_head,
    output logic        o_empty,
    output logic        o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64sd_back.sv =====
// Back end: unrolls queue entries into result beats through an output register.
`default_nettype none

module b64sd_back
    import b64sd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  t_entry                i_head,
    input  wire logic             i_stall,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic                  o_kind,
    output logic [7:0]            o_byte_out,
    output logic                  o_ok,
    output logic [2:0]            o_reason,
    output logic [LEN_W-1:0]      o_byte_count,
    output logic                  o_run_end
);

    logic [1:0]       r_idx;
    logic             r_valid;
    logic             r_kind, r_ok, r_run_end;
    logic [7:0]       r_byte;
    logic [2:0]       r_reason;
    logic [LEN_W-1:0] r_count;

    logic             load, is_data, is_last_rec;
    logic [2:0]       rec_total;
    logic [7:0]       sel_byte;

    assign load        = !r_valid || !i_stall;
    assign rec_total   = 3'(i_head.nbytes) + 3'(i_head.stat);
    assign is_data     = r_idx < i_head.nbytes;
    assign is_last_rec = (3'(r_idx) + 3'd1) == rec_total;
    assign o_pop       = load && !i_empty && is_last_rec;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.b0;
            2'd1:    sel_byte = i_head.b1;
            default: sel_byte = i_head.b2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_idx <= is_last_rec ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_run_end <= is_last_rec;
            if (is_data) begin
                r_kind   <= 1'b0;
                r_byte   <= sel_byte;
                r_ok     <= 1'b0;
                r_reason <= RSN_NONE;
                r_count  <= '0;
            end else begin
                r_kind   <= 1'b1;
                r_byte   <= '0;
                r_ok     <= i_head.ok;
                r_reason <= i_head.reason;
                r_count  <= i_head.count;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_byte_out   = r_byte;
    assign o_ok         = r_ok;
    assign o_reason     = r_reason;
    assign o_byte_count = r_count;
    assign o_run_end    = r_run_end;

endmodule

`default_nettype wire

// ===== verif/base64_stream_decoder_unit_test.sv =====
// Self-checking testbench for base64_stream_decoder_unit: random stream, inline decoder model.
`default_nettype none

module base64_stream_decoder_unit_test
    import b64sd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // result beat kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // one character beat on the input channel
    typedef struct {
        logic       has;
        logic [7:0] ch;
        logic       last;
    } t_char_beat;

    // one result beat as the decoder should emit it
    typedef struct {
        logic             kind;
        logic [7:0]       data;
        logic             ok;
        t_reason          reason;
        logic [LEN_W-1:0] count;
        logic             last;
    } t_dec_beat;

    // receiver stall styles, cycled at random
    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_EVERY4,
        RX_HEAVY
    } t_rx_mode;

    // ---------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ---------------------------------------------------------------------
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    logic                  i_has_byte = 1'b0;
    logic [7:0]            i_char_in  = 8'h00;
    logic                  i_is_last  = 1'b0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    logic                  o_kind;
    logic [7:0]            o_byte_out;
    logic                  o_ok;
    logic [2:0]            o_reason;
    logic [LEN_W-1:0]      o_byte_count;
    logic                  o_run_end;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    base64_stream_decoder_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_has_byte   (i_has_byte),
        .i_char_in    (i_char_in),
        .i_is_last    (i_is_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_byte_out   (o_byte_out),
        .o_ok         (o_ok),
        .o_reason     (o_reason),
        .o_byte_count (o_byte_count),
        .o_run_end    (o_run_end),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Bookkeeping shared by the stimulus, driver and monitor
    // ---------------------------------------------------------------------
    t_char_beat chars_pending[$];   // filled by the stimulus, drained by the driver
    t_dec_beat  beats_expected[$];  // pushed on input accept, popped on output accept
    int unsigned chars_queued = 0;  // beats handed to the driver
    int unsigned chars_taken  = 0;  // beats accepted by the DUT
    int unsigned phase_chars  = 0;  // meaningful beats queued in the current phase
    int unsigned fail_count   = 0;
    int unsigned hold_req     = 0;  // bumped by the stimulus to ask for a long stall
    int unsigned hold_ack     = 0;

    // ---------------------------------------------------------------------
    // Decoder model state: message state plus a shadow of max_output_len
    // ---------------------------------------------------------------------
    logic [LEN_W-1:0]    cap_model  = MAX_LEN_RESET;
    logic [17:0]         dec_accum  = '0;
    logic [1:0]          dec_phase  = '0;
    logic [1:0]          dec_pads   = '0;
    t_reason             dec_err    = RSN_NONE;
    logic [COUNT_BITS_DEF:0] dec_total = '0;   // one bit wider than the count, saturating

    // 6-bit value of an alphabet character, -1 if not in the alphabet
    function automatic int sixbit_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return int'(c) - int'("A");
        if (c >= "a" && c <= "z") return int'(c) - int'("a") + SYM_LOWER_BASE;
        if (c >= "0" && c <= "9") return int'(c) - int'("0") + SYM_DIGIT_BASE;
        if (c == "+") return int'(SYM_PLUS);
        if (c == "/") return int'(SYM_SLASH);
        return -1;
    endfunction

    // alphabet character for a 6-bit value (stimulus side)
    function automatic logic [7:0] sym_char(input int v);
        if (v < SYM_LOWER_BASE) return 8'("A" + v);
        if (v < SYM_DIGIT_BASE) return 8'("a" + v - SYM_LOWER_BASE);
        if (v < int'(SYM_PLUS)) return 8'("0" + v - SYM_DIGIT_BASE);
        if (v == int'(SYM_PLUS)) return "+";
        return "/";
    endfunction

    function automatic logic skip_char(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

    task automatic expect_beat(input logic kind, input logic [7:0] data, input logic ok,
                               input t_reason reason, input logic [LEN_W-1:0] count);
        t_dec_beat b;
        b.kind   = kind;
        b.data   = data;
        b.ok     = ok;
        b.reason = reason;
        b.count  = count;
        b.last   = 1'b0;
        beats_expected.push_back(b);
    endtask

    // a decoded byte leaves only while the message is clean and under capacity,
    // but the total keeps counting so the final check sees the real length
    task automatic stream_out(input logic [7:0] b);
        if (dec_err == RSN_NONE && {1'b0, dec_total} < {2'b0, cap_model})
            expect_beat(KIND_DATA, b, 1'b0, RSN_NONE, '0);
        if (dec_total != '1)
            dec_total = dec_total + 1'b1;
    endtask

    // Work out the result beats caused by one accepted input beat.
    task automatic decode_beat(input logic has, input logic [7:0] c, input logic last);
        int          v;
        int unsigned n_before;
        int unsigned tail;
        logic [23:0] grp;
        logic [LEN_W+2:0] end_total;
        t_reason     verdict;
        t_dec_beat   tmp;
        n_before = beats_expected.size();
        if (has && dec_err == RSN_NONE && !skip_char(c)) begin
            v = sixbit_of(c);
            if (c == CH_PAD) begin
                if (dec_pads >= 2)
                    dec_err = RSN_PADS;
                else
                    dec_pads = dec_pads + 1'b1;
            end else if (v < 0) begin
                // invalid wins over "after pad"
                dec_err = RSN_BAD_CHAR;
            end else if (dec_pads != 0) begin
                dec_err = RSN_AFTER_PAD;
            end else if (dec_phase == 2'd3) begin
                grp       = {dec_accum, 6'(v)};
                dec_accum = '0;
                dec_phase = '0;
                stream_out(grp[23:16]);
                stream_out(grp[15:8]);
                stream_out(grp[7:0]);
            end else begin
                dec_accum = {dec_accum[11:0], 6'(v)};
                dec_phase = dec_phase + 1'b1;
            end
        end
        if (last) begin
            verdict = dec_err;
            tail    = (dec_phase >= 2) ? dec_phase - 1 : 0;
            if (verdict == RSN_NONE && ((int'(dec_phase) + int'(dec_pads)) % 4) != 0)
                verdict = RSN_LENGTH;
            end_total = dec_total + tail;
            if (verdict == RSN_NONE && end_total > cap_model)
                verdict = RSN_CAPACITY;
            if (verdict == RSN_NONE) begin
                // tail bytes only go out on success
                if (dec_phase == 2'd2) begin
                    expect_beat(KIND_DATA, dec_accum[11:4], 1'b0, RSN_NONE, '0);
                end else if (dec_phase == 2'd3) begin
                    expect_beat(KIND_DATA, dec_accum[17:10], 1'b0, RSN_NONE, '0);
                    expect_beat(KIND_DATA, dec_accum[9:2], 1'b0, RSN_NONE, '0);
                end
                expect_beat(KIND_STATUS, 8'h00, 1'b1, RSN_NONE, end_total[LEN_W-1:0]);
            end else begin
                expect_beat(KIND_STATUS, 8'h00, 1'b0, verdict, '0);
            end
            dec_accum = '0;
            dec_phase = '0;
            dec_pads  = '0;
            dec_err   = RSN_NONE;
            dec_total = '0;
        end
        // flag the final beat of this input beat
        if (beats_expected.size() > n_before) begin
            tmp      = beats_expected.pop_back();
            tmp.last = 1'b1;
            beats_expected.push_back(tmp);
        end
    endtask

    // ---------------------------------------------------------------------
    // Driver: bursts of random length, random gaps, payload held while stalled
    // ---------------------------------------------------------------------
    t_char_beat  next_char;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            // beat taken at this edge: predict from the values that were on the port
            if (i_valid && !o_stall) begin
                decode_beat(i_has_byte, i_char_in, i_is_last);
                chars_taken <= chars_taken + 1;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (chars_pending.size() != 0) begin
                    next_char = chars_pending.pop_front();
                    i_has_byte <= next_char.has;
                    i_char_in  <= next_char.ch;
                    i_is_last  <= next_char.last;
                    i_valid    <= 1'b1;
                    if (burst_left <= 1) begin
                        // new burst; about a third of them run back to back
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver stall pattern, with an occasional long hold-off on request
    // ---------------------------------------------------------------------
    t_rx_mode    rx_mode   = RX_FREE;
    int unsigned mode_left = 0;
    int unsigned hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_ack != hold_req) begin
            // long back-pressure: fills the DUT queue so it stalls its input
            hold_ack  <= hold_req;
            hold_left <= 300;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= t_rx_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(20, 150);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_FREE:   i_stall <= 1'b0;
                RX_COIN:   i_stall <= 1'($urandom_range(0, 1));
                RX_EVERY4: i_stall <= (mode_left[1:0] == 2'd0);
                default:   i_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: every accepted result beat against the oldest expectation
    // ---------------------------------------------------------------------
    t_dec_beat want;

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (beats_expected.size() == 0) begin
                $error("result beat with nothing expected: kind=%0d byte=0x%0h reason=%0d",
                       o_kind, o_byte_out, o_reason);
                fail_count++;
            end else begin
                want = beats_expected.pop_front();
                check_field("kind",       want.kind,   o_kind);
                check_field("byte_out",   want.data,   o_byte_out);
                check_field("ok",         want.ok,     o_ok);
                check_field("reason",     want.reason, o_reason);
                check_field("byte_count", want.count,  o_byte_count);
                check_field("run_end",    want.last,   o_run_end);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic push_char(input logic has, input logic [7:0] c, input logic last);
        t_char_beat b;
        b.has  = has;
        b.ch   = c;
        b.last = last;
        chars_pending.push_back(b);
        chars_queued++;
        if (has || last)
            phase_chars++;
    endtask

    task automatic push_text(input string s, input logic end_msg);
        for (int i = 0; i < s.len(); i++)
            push_char(1'b1, s[i], end_msg && (i == s.len() - 1));
    endtask

    // One message: mostly well-formed groups with an optional padded tail,
    // whitespace and ignored beats sprinkled in; some get one defect.
    task automatic gen_message(input logic broken);
        logic [7:0] txt[$];
        int         groups;
        int         tail;
        int         pos;
        logic       end_on_char;
        groups = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
        tail   = $urandom_range(0, 2);
        repeat (groups * 4) txt.push_back(sym_char($urandom_range(0, 63)));
        if (tail == 1) begin
            repeat (2) txt.push_back(sym_char($urandom_range(0, 63)));
            repeat (2) txt.push_back(CH_PAD);
        end else if (tail == 2) begin
            repeat (3) txt.push_back(sym_char($urandom_range(0, 63)));
            txt.push_back(CH_PAD);
        end
        if (broken) begin
            pos = (txt.size() == 0) ? 0 : $urandom_range(0, txt.size() - 1);
            case ($urandom_range(0, 4))
                0: begin
                    if (txt.size() != 0) txt[pos] = 8'($urandom_range(0, 255));
                    else txt.push_back(8'($urandom_range(0, 255)));
                end
                1: if (txt.size() != 0) void'(txt.pop_back());   // short group or lost pad
                2: txt.push_back(CH_PAD);                      // extra pad
                3: begin                                       // symbol after a pad
                    txt.push_back(CH_PAD);
                    txt.push_back(sym_char($urandom_range(0, 63)));
                end
                default: txt.insert(pos, 8'($urandom_range(0, 255)));
            endcase
        end
        end_on_char = (txt.size() != 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < txt.size(); i++) begin
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0: push_char(1'b1, 8'h20, 1'b0);
                    1: push_char(1'b1, 8'h09, 1'b0);
                    2: push_char(1'b1, 8'h0D, 1'b0);
                    default: push_char(1'b1, 8'h0A, 1'b0);
                endcase
            end
            if ($urandom_range(0, 15) == 0)
                push_char(1'b0, 8'($urandom_range(0, 255)), 1'b0);
            push_char(1'b1, txt[i], end_on_char && (i == txt.size() - 1));
        end
        if (!end_on_char)
            push_char(1'b0, 8'($urandom_range(0, 255)), 1'b1);   // bare end marker
    endtask

    // Sender pause: everything accepted, every result back, then the pipe
    // given time to go quiet (beats that make no result may still be inside).
    task automatic drain_and_settle();
        while (chars_taken != chars_queued || beats_expected.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // APB write of max_output_len; only called while the decoder is idle
    task automatic set_max_len(input logic [LEN_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(REG_MAX_LEN));
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // register took the value at this edge
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        cap_model = value;
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        logic [LEN_W-1:0] cap;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset capacity.
        push_char(1'b0, 8'h00, 1'b1);        // empty message: ok, count 0
        push_text("/+\t0 z", 1'b1);          // top alphabet values, blanks inside a group
        push_char(1'b0, 8'hA5, 1'b0);        // beat with nothing in it
        push_text("TQ==", 1'b1);             // two-symbol tail, ends on a pad
        push_text("TWF", 1'b0);
        push_char(1'b0, 8'hFF, 1'b1);        // unpadded tail: bad length
        push_char(1'b1, 8'h00, 1'b0);        // invalid character
        push_text("\r\n", 1'b0);
        push_char(1'b0, 8'h5A, 1'b1);
        push_text("===", 1'b1);              // third pad
        push_text("TQ=A", 1'b1);             // symbol after a pad
        push_char(1'b1, CH_PAD, 1'b0);       // invalid after a pad reports bad char
        push_char(1'b1, 8'hFF, 1'b1);
        drain_and_settle();

        // Random phases, each at its own capacity. Small capacities make the
        // decoder cut its output and fail; the two extremes come in too.
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: cap = '0;
                1: cap = 24'd1;
                2: cap = 24'd2;
                3: cap = 24'd3;
                4: cap = 24'd7;
                5: cap = LEN_W'($urandom_range(5, 40));
                6: cap = '1;
                7: cap = LEN_W'($urandom_range(0, 24'hFF_FFFF));
                default: cap = 24'd4;
            endcase
            set_max_len(cap);
            phase_chars = 0;
            while (phase_chars < 56)
                gen_message($urandom_range(0, 3) == 0);
            // long receiver hold-off while the sender still has plenty to offer
            if (p == 2 || p == 6)
                hold_req++;
            drain_and_settle();
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Run limit: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
